@@ rtl/spq_pkg.sv @@
// Shared types, constants and helpers for the sorted priority queue.
// No dependencies; every other file of the block imports this package.
package spq_pkg;

   localparam int DEPTH    = 16;
   localparam int TAG_BITS = 32;

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CAP_W   = 5;
   localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int SCORE_W = 16;
   localparam int PTAG_W  = 32;

   // operation codes of the request channel
   localparam logic [1:0] FN_INSERT = 2'd0;
   localparam logic [1:0] FN_REMOVE = 2'd1;
   localparam logic [1:0] FN_READ   = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // cell row operations
   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_ROTATE = 2'd3;

   typedef struct packed {
      logic [SCORE_W-1:0]  score;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [CNT_W-1:0] count;
      entry_type        new_entry;
   } ctl_type;

   function automatic logic [TAG_BITS-1:0] to_tag(input logic [PTAG_W-1:0] v);
      return TAG_BITS'(v);
   endfunction

   function automatic logic [PTAG_W-1:0] from_tag(input logic [TAG_BITS-1:0] t);
      return PTAG_W'(t);
   endfunction

endpackage

@@ rtl/spq_if.sv @@
// Channel interfaces of the sorted priority queue: request, response, register write.
// Depends on spq_pkg for field widths.
interface spq_req_if import spq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          func;
   logic [SCORE_W-1:0]  score;
   logic [PTAG_W-1:0]   name_tag;

   modport source (output valid, func, score, name_tag, input ready);
   modport sink   (input valid, func, score, name_tag, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic [SCORE_W-1:0]  entry_score;
   logic [PTAG_W-1:0]   entry_tag;
   logic                last;

   modport source (output valid, status, entry_score, entry_tag, last, input ready);
   modport sink   (input valid, status, entry_score, entry_tag, last, output ready);
endinterface

interface spq_csr_if import spq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ rtl/spq_cell.sv @@
// One slot of the sorted entry row: holds an entry and trades it with its neighbors.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
   input  logic             clock,
   input  ctl_type          ctl,
   input  logic [IDX_W-1:0] cell_idx,
   input  entry_type        prev_entry,
   input  logic             prev_gt,
   input  entry_type        next_entry,
   input  entry_type        head_entry,
   output entry_type        entry,
   output logic             gt
);

   entry_type entry_ff, entry_in;
   logic      occupied, at_end, at_wrap;

   assign occupied = CNT_W'(cell_idx) < ctl.count;
   assign at_end   = CNT_W'(cell_idx) == ctl.count;
   assign at_wrap  = (CNT_W'(cell_idx) + CNT_W'(1)) == ctl.count;

   // scores are sorted descending, so this flag is monotone along the occupied cells
   assign gt = occupied && ($signed(ctl.new_entry.score) > $signed(entry_ff.score));

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         OP_INSERT: begin
            if (prev_gt) entry_in = prev_entry;
            else if (gt || at_end) entry_in = ctl.new_entry;
         end
         OP_REMOVE: entry_in = next_entry;
         OP_ROTATE: entry_in = at_wrap ? head_entry : next_entry;
         default:   entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ rtl/sorted_priority_queue.sv @@
// Sorted priority queue: a row of DEPTH cells kept in descending score order.
// Insert and delete: cell row and response register update in the cycle after accept.
// Read-out: N responses from the head cell as the occupied cells rotate, one per cycle unless
// the response stalls; a busy flag is registered before the first; next taken after the last.
// Reset (synchronous, active high) clears entry count and response valid and sets
// capacity to 16; entry contents are not cleared.
module sorted_priority_queue import spq_pkg::*; (
   input logic        clock,
   input logic        reset,
   spq_req_if.sink    req,
   spq_rsp_if.source  rsp,
   spq_csr_if.sink    csr
);

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CAP_W-1:0]   capacity_ff;
   logic               rd_busy_ff, rd_busy_in;
   logic [CNT_W-1:0]   rd_left_ff, rd_left_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic [PTAG_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic               rsp_last_ff, rsp_last_in;

   logic             out_free, accept, full;
   logic [CMP_W-1:0] limit;
   logic [1:0]       op;
   ctl_type          ctl;

   entry_type             cell_entry [DEPTH];
   entry_type             prev_e [DEPTH];
   entry_type             next_e [DEPTH];
   logic [DEPTH-1:0]      cell_gt;
   logic [DEPTH-1:0]      prev_gt;

   assign csr.ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = !rd_busy_ff && out_free;
   assign accept    = req.valid && req.ready;

   assign limit = (CMP_W'(capacity_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(capacity_ff);
   assign full  = CMP_W'(count_ff) >= limit;

   assign ctl.op        = op;
   assign ctl.count     = count_ff;
   assign ctl.new_entry = '{score: req.score, tag: to_tag(req.name_tag)};

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign prev_e[g]  = ctl.new_entry;
         assign prev_gt[g] = 1'b0;
      end else begin : g_body
         assign prev_e[g]  = cell_entry[g-1];
         assign prev_gt[g] = cell_gt[g-1];
      end
      assign next_e[g] = cell_entry[(g + 1) % DEPTH];

      spq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_idx   (IDX_W'(g)),
         .prev_entry (prev_e[g]),
         .prev_gt    (prev_gt[g]),
         .next_entry (next_e[g]),
         .head_entry (cell_entry[0]),
         .entry      (cell_entry[g]),
         .gt         (cell_gt[g])
      );
   end

   always_comb begin
      op            = OP_HOLD;
      count_in      = count_ff;
      rd_busy_in    = rd_busy_ff;
      rd_left_in    = rd_left_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_score_in  = rsp_score_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_last_in   = rsp_last_ff;

      if (accept) begin
         unique case (req.func)
            FN_INSERT: begin
               rsp_valid_in  = 1'b1;
               rsp_score_in  = '0;
               rsp_tag_in    = '0;
               rsp_last_in   = 1'b1;
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  rsp_status_in = ST_OK;
                  op            = OP_INSERT;
                  count_in      = count_ff + CNT_W'(1);
               end
            end
            FN_REMOVE: begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (count_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
                  rsp_score_in  = '0;
                  rsp_tag_in    = '0;
               end else begin
                  rsp_status_in = ST_OK;
                  rsp_score_in  = cell_entry[0].score;
                  rsp_tag_in    = from_tag(cell_entry[0].tag);
                  op            = OP_REMOVE;
                  count_in      = count_ff - CNT_W'(1);
               end
            end
            FN_READ: begin
               if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_EMPTY;
                  rsp_score_in  = '0;
                  rsp_tag_in    = '0;
                  rsp_last_in   = 1'b1;
               end else begin
                  rd_busy_in = 1'b1;
                  rd_left_in = count_ff;
               end
            end
            default: ;
         endcase
      end else if (rd_busy_ff && out_free) begin
         // emit the head and rotate the occupied cells by one
         op            = OP_ROTATE;
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_score_in  = cell_entry[0].score;
         rsp_tag_in    = from_tag(cell_entry[0].tag);
         rsp_last_in   = rd_left_ff == CNT_W'(1);
         rd_left_in    = rd_left_ff - CNT_W'(1);
         if (rd_left_ff == CNT_W'(1)) rd_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         capacity_ff  <= CAP_W'(16);
         rd_busy_ff   <= 1'b0;
         rd_left_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_busy_ff   <= rd_busy_in;
         rd_left_ff   <= rd_left_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid && csr.ready) capacity_ff <= csr.data;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.entry_score = rsp_score_ff;
   assign rsp.entry_tag   = rsp_tag_ff;
   assign rsp.last        = rsp_last_ff;

endmodule

@@ rtl/spq_checker.sv @@
// Port-level checks on the sorted priority queue response channel, with its bind.
// Depends on spq_pkg and on the sorted_priority_queue top level.
module spq_checker import spq_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic [SCORE_W-1:0] rsp_entry_score,
   input logic [PTAG_W-1:0]  rsp_entry_tag,
   input logic               rsp_last
);

   // a stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_score) && $stable(rsp_entry_tag) && $stable(rsp_last))
      else $error("response changed while stalled");

   // full and empty responses always close their operation
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last)
      else $error("error response without last");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_EMPTY)
         |-> rsp_entry_score == '0 && rsp_entry_tag == '0)
      else $error("error response carries entry data");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_status      (rsp.status),
   .rsp_entry_score (rsp.entry_score),
   .rsp_entry_tag   (rsp.entry_tag),
   .rsp_last        (rsp.last)
);

@@ dv/sorted_priority_queue_tb.sv @@
`timescale 1ns / 100ps
// Testbench for sorted_priority_queue: directed and random request traffic checked
// against a sorted-array predictor. Depends on rtl/spq_pkg.sv, rtl/spq_if.sv and rtl/sorted_priority_queue.sv.
module sorted_priority_queue_tb;
   import spq_pkg::*;

   localparam logic [1:0] FN_UNUSED = 2'd3;  // the block drops this code
   localparam int RANDOM_ITEMS    = 100;
   localparam int SETTLE_CYCLES   = 6;
   localparam int END_CYCLES      = 20;
   localparam int RSP_HOLD_CYCLES = 80;
   localparam int MAX_REPORTS     = 10;

   typedef struct {
      logic [1:0]         status;
      logic [SCORE_W-1:0] score;
      logic [PTAG_W-1:0]  tag;
      logic               last;
   } response_type;

   logic clock;
   logic reset;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();
   spq_csr_if csr_bus ();

   sorted_priority_queue uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // predicted queue contents and setting
   logic signed [SCORE_W-1:0] sorted_scores [DEPTH];
   logic [TAG_BITS-1:0]       sorted_tags [DEPTH];
   int                        held_entries;
   int                        capacity_reg;
   response_type              due_responses [$];

   int  error_count;
   int  items_sent;
   int  ignored_sent;
   int  responses_checked;
   int  full_seen;
   int  empty_seen;
   int  readout_entries;
   int  capacity_writes;
   bit  req_idling;
   bit  rsp_idling;
   bit  rsp_hold_request;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("timeout: %0d responses still due", due_responses.size());
      $display("sorted_priority_queue_tb: errors");
      $finish;
   end

   function automatic int idle_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic void queue_response(input logic [1:0] st,
                                          input logic [SCORE_W-1:0] sc,
                                          input logic [PTAG_W-1:0] tg,
                                          input logic lst);
      due_responses.push_back('{st, sc, tg, lst});
   endfunction

   // Next-state and responses of the sorted array for one accepted request
   function automatic void apply_queue_op(input logic [1:0] fn,
                                          input logic signed [SCORE_W-1:0] sc,
                                          input logic [PTAG_W-1:0] nt);
      int limit;
      int slot;
      limit = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
      case (fn)
         FN_INSERT: begin
            if (held_entries >= limit) begin
               queue_response(ST_FULL, '0, '0, 1'b1);
            end else begin
               slot = held_entries;
               // strictly greater, so equal scores keep arrival order
               for (int i = 0; i < held_entries; i++) begin
                  if (sc > sorted_scores[i]) begin
                     slot = i;
                     break;
                  end
               end
               for (int i = held_entries; i > slot; i--) begin
                  sorted_scores[i] = sorted_scores[i-1];
                  sorted_tags[i]   = sorted_tags[i-1];
               end
               sorted_scores[slot] = sc;
               sorted_tags[slot]   = TAG_BITS'(nt);
               held_entries++;
               queue_response(ST_OK, '0, '0, 1'b1);
            end
         end
         FN_REMOVE: begin
            if (held_entries == 0) begin
               queue_response(ST_EMPTY, '0, '0, 1'b1);
            end else begin
               queue_response(ST_OK, sorted_scores[0], PTAG_W'(sorted_tags[0]), 1'b1);
               for (int i = 0; i + 1 < held_entries; i++) begin
                  sorted_scores[i] = sorted_scores[i+1];
                  sorted_tags[i]   = sorted_tags[i+1];
               end
               held_entries--;
            end
         end
         FN_READ: begin
            if (held_entries == 0) begin
               queue_response(ST_EMPTY, '0, '0, 1'b1);
            end else begin
               for (int i = 0; i < held_entries; i++)
                  queue_response(ST_OK, sorted_scores[i], PTAG_W'(sorted_tags[i]),
                                 (i + 1 == held_entries));
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 3))
         0: return SCORE_W'(int'($urandom_range(0, 4)) - 2);  // dense, forces ties
         1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         default: return SCORE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_request(input logic [1:0] fn, input logic [SCORE_W-1:0] sc,
                               input logic [PTAG_W-1:0] nt);
      int gap;
      gap = (req_idling && $urandom_range(0, 2) == 0) ? idle_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.func     <= fn;
      req_bus.score    <= sc;
      req_bus.name_tag <= nt;
      req_bus.valid    <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      apply_queue_op(fn, sc, nt);
      if (fn == FN_UNUSED) ignored_sent++;
      else items_sent++;
   endtask

   // Stop offering, let every due response arrive, then let the block settle
   task automatic drain_queue();
      req_bus.valid <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input int value);
      csr_bus.data  <= CAP_W'(value);
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      capacity_reg = value & 31;
      capacity_writes++;
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_empty_and_extremes();
      send_request(FN_REMOVE, 16'h1234, 32'hdead_beef);
      send_request(FN_READ, '0, '0);
      send_request(FN_INSERT, 16'h0000, 32'h0000_000a);
      send_request(FN_INSERT, 16'h0000, 32'h0000_000b);
      send_request(FN_INSERT, 16'h7fff, 32'hffff_ffff);
      send_request(FN_INSERT, 16'h8000, 32'h0000_0000);
      send_request(FN_INSERT, 16'h0001, 32'h5555_5555);
      send_request(FN_INSERT, 16'hffff, 32'haaaa_aaaa);
      send_request(FN_INSERT, 16'h0000, 32'h0000_000c);
      send_request(FN_UNUSED, 16'h7fff, 32'hffff_ffff);
      send_request(FN_READ, 16'hffff, 32'hffff_ffff);
      send_request(FN_REMOVE, '0, '0);
      send_request(FN_REMOVE, '0, '0);
      send_request(FN_READ, '0, '0);
   endtask

   task automatic test_capacity_limits();
      drain_queue();
      write_capacity(0);
      send_request(FN_INSERT, 16'h0100, 32'h0000_0100);
      send_request(FN_REMOVE, '0, '0);
      drain_queue();
      // capacity of 2: inserts, a read-out and removes, down to empty and up to the limit
      write_capacity(2);
      send_request(FN_INSERT, 16'h0200, 32'h0000_0200);
      send_request(FN_READ, '0, '0);
      send_request(FN_REMOVE, '0, '0);
      send_request(FN_REMOVE, '0, '0);
      send_request(FN_INSERT, 16'h0300, 32'h0000_0300);
      send_request(FN_REMOVE, '0, '0);
      send_request(FN_INSERT, 16'hfe00, 32'h0000_fe00);
      send_request(FN_INSERT, 16'hfd00, 32'h0000_fd00);
      drain_queue();
      write_capacity(31);
      send_request(FN_INSERT, 16'h0400, 32'h0000_0400);
      send_request(FN_READ, '0, '0);
   endtask

   task automatic test_fill_under_backpressure();
      drain_queue();
      write_capacity(16);
      req_idling = 1'b0;
      while (held_entries > 0) send_request(FN_REMOVE, '0, '0);
      // receiver stalls while the sender keeps pushing past full
      rsp_hold_request = 1'b1;
      for (int i = 0; i < DEPTH + 4; i++)
         send_request(FN_INSERT, pick_score(), $urandom());
      send_request(FN_READ, '0, '0);
      // sender pauses until the backlog is gone
      drain_queue();
      send_request(FN_REMOVE, '0, '0);
      send_request(FN_READ, '0, '0);
   endtask

   task automatic test_random_traffic();
      int start_count;
      int insert_pct;
      int phase_len;
      int roll;
      logic [1:0] fn;
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         drain_queue();
         case ($urandom_range(0, 7))
            0: write_capacity(0);
            1: write_capacity(1);
            2: write_capacity(5);
            3: write_capacity(16);
            4: write_capacity(17);
            5: write_capacity(31);
            default: write_capacity($urandom_range(0, 31));
         endcase
         case ($urandom_range(0, 2))
            0: insert_pct = 75;
            1: insert_pct = 50;
            default: insert_pct = 30;
         endcase
         req_idling = $urandom_range(0, 3) != 0;
         rsp_idling = $urandom_range(0, 3) != 0;
         phase_len  = $urandom_range(15, 30);
         for (int n = 0; n < phase_len; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) fn = FN_UNUSED;
            else if (roll < 13) fn = FN_READ;
            else if (roll < 13 + insert_pct * 87 / 100) fn = FN_INSERT;
            else fn = FN_REMOVE;
            send_request(fn, pick_score(), $urandom());
         end
      end
   endtask

   // response ready: random gaps, quiet stretches, and one long hold on request
   initial begin : rsp_ready_driver
      int hold_left;
      int gap_left;
      hold_left = 0;
      gap_left  = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (gap_left > 0) begin
            rsp_bus.ready <= 1'b0;
            gap_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (rsp_idling && $urandom_range(0, 3) == 0) gap_left = idle_gap();
         end
      end
   end

   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         responses_checked++;
         if (rsp_bus.status == ST_FULL) full_seen++;
         if (rsp_bus.status == ST_EMPTY) empty_seen++;
         if (rsp_bus.status == ST_OK && rsp_bus.entry_tag != '0) readout_entries++;
         if (due_responses.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected response st=%0d score=%0d tag=%h last=%0d",
                        $realtime, rsp_bus.status, $signed(rsp_bus.entry_score),
                        rsp_bus.entry_tag, rsp_bus.last);
         end else begin
            want = due_responses.pop_front();
            if (rsp_bus.status !== want.status || rsp_bus.entry_score !== want.score ||
                rsp_bus.entry_tag !== want.tag || rsp_bus.last !== want.last) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: mismatch exp st=%0d score=%0d tag=%h last=%0d",
                           $realtime, want.status, $signed(want.score), want.tag,
                           want.last);
                  $display("   got st=%0d score=%0d tag=%h last=%0d",
                           rsp_bus.status, $signed(rsp_bus.entry_score),
                           rsp_bus.entry_tag, rsp_bus.last);
               end
            end
         end
      end
   end

   initial begin
      error_count       = 0;
      items_sent        = 0;
      ignored_sent      = 0;
      responses_checked = 0;
      full_seen         = 0;
      empty_seen        = 0;
      readout_entries   = 0;
      capacity_writes   = 0;
      held_entries      = 0;
      capacity_reg      = DEPTH;
      req_idling        = 1'b1;
      rsp_idling        = 1'b1;
      rsp_hold_request  = 1'b0;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.func     <= FN_INSERT;
      req_bus.score    <= '0;
      req_bus.name_tag <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.data     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_and_extremes();
      test_capacity_limits();
      test_fill_under_backpressure();
      test_random_traffic();

      req_bus.valid <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);

      $display("run: %0d requests (+%0d ignored codes), %0d responses, %0d capacity writes",
               items_sent, ignored_sent, responses_checked, capacity_writes);
      $display("run: %0d full and %0d empty reports, %0d nonzero-tag entries returned",
               full_seen, empty_seen, readout_entries);
      if (error_count == 0) begin
         $display("sorted_priority_queue_tb: clean");
      end else begin
         $display("sorted_priority_queue_tb: errors");
      end
      $finish;
   end

endmodule
